/* sv/ppr_pkg.sv */
// shared constants and helpers for the plane point and ray test
`timescale 1ns / 1ps
package ppr_pkg;

  localparam int COORD_WIDTH = 32;
  localparam int FRAC_BITS   = 16;

  // command codes
  localparam logic [1:0] CMD_RAY     = 2'd1;
  localparam logic [1:0] CMD_SEGMENT = 2'd2;

  // side codes
  localparam logic [1:0] SIDE_ON    = 2'd0;
  localparam logic [1:0] SIDE_FRONT = 2'd1;
  localparam logic [1:0] SIDE_BACK  = 2'd2;

  // configuration register indexes
  localparam logic [1:0] REG_NORMAL_X     = 2'd0;
  localparam logic [1:0] REG_NORMAL_Y     = 2'd1;
  localparam logic [1:0] REG_NORMAL_Z     = 2'd2;
  localparam logic [1:0] REG_PLANE_OFFSET = 2'd3;

  // width of an exact plane value: three products plus the shifted offset
  function automatic int plane_width(int cw, int fb);
    int w;
    w = (2 * cw > cw + fb + 1) ? 2 * cw : cw + fb + 1;
    return w + 3;
  endfunction

endpackage

/* sv/ppr_front.sv */
// front stages: products, plane values, operand selection and magnitudes
`timescale 1ns / 1ps
module ppr_front #(
  parameter int CW = ppr_pkg::COORD_WIDTH,
  parameter int FB = ppr_pkg::FRAC_BITS,
  parameter int SW = ppr_pkg::plane_width(ppr_pkg::COORD_WIDTH, ppr_pkg::FRAC_BITS)
) (
  input  logic                 clk_i,
  input  logic                 en_i,
  input  logic [1:0]           cmd_i,
  input  logic [2:0][CW-1:0]   nrm_i,
  input  logic [CW-1:0]        off_i,
  input  logic [2:0][CW-1:0]   p_i,
  input  logic [2:0][CW-1:0]   v_i,
  output logic [2:0][CW-1:0]   p_o,
  output logic [2:0][CW:0]     m_mag_o,
  output logic [2:0]           neg_o,
  output logic [SW:0]          s_mag_o,
  output logic                 s_neg_o,
  output logic [SW:0]          den_mag_o,
  output logic [1:0]           side_o,
  output logic                 hit_o
);
  import ppr_pkg::*;

  function automatic logic [1:0] side_of(logic [SW-1:0] val);
    logic [1:0] r;
    if (val == '0) r = SIDE_ON;
    else if (val[SW-1]) r = SIDE_BACK;
    else r = SIDE_FRONT;
    return r;
  endfunction

  // stage 1
  logic [1:0]           cmd1_q;
  logic [2:0][CW-1:0]   p1_q;
  logic [2:0][CW:0]     m1_q;
  logic [2:0][2*CW-1:0] pp1_q;
  logic [2:0][2*CW-1:0] pv1_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      cmd1_q <= cmd_i;
      p1_q   <= p_i;
      for (int k = 0; k < 3; k++) begin
        pp1_q[k] <= (2*CW)'($signed(nrm_i[k]) * $signed(p_i[k]));
        pv1_q[k] <= (2*CW)'($signed(nrm_i[k]) * $signed(v_i[k]));
        if (cmd_i == CMD_SEGMENT) begin
          m1_q[k] <= (CW+1)'($signed(v_i[k])) - (CW+1)'($signed(p_i[k]));
        end else begin
          m1_q[k] <= (CW+1)'($signed(v_i[k]));
        end
      end
    end
  end

  // stage 2: plane values at both points and the normal dot product
  logic [1:0]         cmd2_q;
  logic [2:0][CW-1:0] p2_q;
  logic [2:0][CW:0]   m2_q;
  logic [SW-1:0]      s2_q, dot2_q, se2_q;
  logic signed [SW-1:0] dsh, s_d, dot_d;

  always_comb begin
    dsh   = SW'($signed(off_i)) <<< FB;
    s_d   = SW'($signed(pp1_q[0])) + SW'($signed(pp1_q[1])) + SW'($signed(pp1_q[2])) + dsh;
    dot_d = SW'($signed(pv1_q[0])) + SW'($signed(pv1_q[1])) + SW'($signed(pv1_q[2]));
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      cmd2_q <= cmd1_q;
      p2_q   <= p1_q;
      m2_q   <= m1_q;
      s2_q   <= s_d;
      dot2_q <= dot_d;
      se2_q  <= dot_d + dsh;
    end
  end

  // stage 3: divisor choice, magnitudes, signs and the hit test
  logic signed [SW:0] den, s_ext;
  logic [1:0]         side_s, side_e;
  logic               hit_d;

  always_comb begin
    s_ext  = (SW+1)'($signed(s2_q));
    side_s = side_of(s2_q);
    side_e = side_of(se2_q);
    if (cmd2_q == CMD_RAY) begin
      den   = (SW+1)'($signed(dot2_q));
      hit_d = (dot2_q != '0);
    end else begin
      den   = (SW+1)'($signed(se2_q)) - s_ext;
      hit_d = (cmd2_q == CMD_SEGMENT) && (side_s != side_e);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      p_o       <= p2_q;
      s_mag_o   <= s_ext[SW] ? -s_ext : s_ext;
      s_neg_o   <= s_ext[SW];
      den_mag_o <= den[SW] ? -den : den;
      side_o    <= side_s;
      hit_o     <= hit_d;
      for (int k = 0; k < 3; k++) begin
        m_mag_o[k] <= m2_q[k][CW] ? -m2_q[k] : m2_q[k];
        // quotient sign of m * (-s) / den
        neg_o[k]   <= m2_q[k][CW] ^ ~s_ext[SW] ^ den[SW];
      end
    end
  end

endmodule

/* sv/ppr_div.sv */
// pipelined restoring divider, one quotient bit per stage
`timescale 1ns / 1ps
module ppr_div #(
  parameter int QB = ppr_pkg::COORD_WIDTH + 1,
  parameter int DW = 8,
  parameter int TW = 8
) (
  input  logic          clk_i,
  input  logic          en_i,
  input  logic [DW-1:0] rem_i,
  input  logic [QB-1:0] low_i,
  input  logic [DW-1:0] div_i,
  input  logic [TW-1:0] tag_i,
  output logic [QB-1:0] quo_o,
  output logic [TW-1:0] tag_o
);
  logic [DW-1:0] rem_s [QB+1];
  logic [QB-1:0] low_s [QB+1];
  logic [DW-1:0] div_s [QB+1];
  logic [QB-1:0] quo_s [QB+1];
  logic [TW-1:0] tag_s [QB+1];

  assign rem_s[0] = rem_i;
  assign low_s[0] = low_i;
  assign div_s[0] = div_i;
  assign quo_s[0] = '0;
  assign tag_s[0] = tag_i;

  for (genvar g = 0; g < QB; g++) begin : g_stage
    logic [DW:0] trial, diff;
    logic        ge;

    always_comb begin
      trial = {rem_s[g], low_s[g][QB-1]};
      diff  = trial - {1'b0, div_s[g]};
      ge    = (trial >= {1'b0, div_s[g]});
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_s[g+1] <= ge ? diff[DW-1:0] : trial[DW-1:0];
        low_s[g+1] <= {low_s[g][QB-2:0], 1'b0};
        div_s[g+1] <= div_s[g];
        quo_s[g+1] <= {quo_s[g][QB-2:0], ge};
        tag_s[g+1] <= tag_s[g];
      end
    end
  end

  assign quo_o = quo_s[QB];
  assign tag_o = tag_s[QB];

endmodule

/* sv/ppr_coord.sv */
// one coordinate lane: scale, divide with rounding, offset and saturate
`timescale 1ns / 1ps
module ppr_coord #(
  parameter int CW = ppr_pkg::COORD_WIDTH,
  parameter int SW = ppr_pkg::plane_width(ppr_pkg::COORD_WIDTH, ppr_pkg::FRAC_BITS)
) (
  input  logic          clk_i,
  input  logic          en_i,
  input  logic [CW-1:0] p_i,
  input  logic [CW:0]   m_mag_i,
  input  logic          neg_i,
  input  logic [SW:0]   ns_mag_i,
  input  logic [SW:0]   den_mag_i,
  output logic [CW-1:0] h_o,
  output logic          sat_o
);
  localparam int AW = SW + 1;
  localparam int H  = AW / 2;
  localparam int HW = AW - H;
  localparam int NW = CW + 1 + AW;
  localparam int XW = NW + 2;
  localparam int DW = AW + 1;
  localparam int QB = CW + 1;
  localparam int TW = CW + 2;

  // two partial products
  logic [CW+H:0]    pl_q;
  logic [CW+HW:0]   ph_q;
  logic [CW-1:0]    p1_q, p2_q, p3_q;
  logic             neg1_q, neg2_q, neg3_q;
  logic [AW-1:0]    den1_q, den2_q;
  logic [NW-1:0]    n2_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      pl_q   <= m_mag_i * ns_mag_i[H-1:0];
      ph_q   <= m_mag_i * ns_mag_i[AW-1:H];
      p1_q   <= p_i;
      neg1_q <= neg_i;
      den1_q <= den_mag_i;
      n2_q   <= (NW'(ph_q) << H) + NW'(pl_q);
      p2_q   <= p1_q;
      neg2_q <= neg1_q;
      den2_q <= den1_q;
    end
  end

  // round to nearest: floor((2n + d) / 2d)
  logic [XW-1:0] x_d;
  logic [DW-1:0] y_d;
  logic          ovf_d;
  logic [DW-1:0] rem_q, div_q;
  logic [QB-1:0] low_q;
  logic          ovf_q;

  always_comb begin
    x_d   = {1'b0, n2_q, 1'b0} + XW'(den2_q);
    y_d   = {den2_q, 1'b0};
    ovf_d = (x_d[XW-1:QB] >= {1'b0, y_d});
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_q  <= x_d[QB+DW-1:QB];
      low_q  <= x_d[QB-1:0];
      div_q  <= y_d;
      ovf_q  <= ovf_d;
      p3_q   <= p2_q;
      neg3_q <= neg2_q;
    end
  end

  logic [QB-1:0] quo;
  logic [TW-1:0] tag;

  ppr_div #(.QB(QB), .DW(DW), .TW(TW)) u_div (
    .clk_i (clk_i),
    .en_i  (en_i),
    .rem_i (rem_q),
    .low_i (low_q),
    .div_i (div_q),
    .tag_i ({ovf_q, neg3_q, p3_q}),
    .quo_o (quo),
    .tag_o (tag)
  );

  localparam logic signed [CW+2:0] MAXV = $signed({4'b0000, {(CW-1){1'b1}}});
  localparam logic signed [CW+2:0] MINV = $signed({4'b1111, {(CW-1){1'b0}}});

  logic signed [CW+2:0] t, hs, hv;
  logic                 sat_d;

  always_comb begin
    t = tag[CW] ? -$signed({2'b00, quo}) : $signed({2'b00, quo});
    hs = (CW+3)'($signed(tag[CW-1:0])) + t;
    sat_d = 1'b1;
    if (tag[CW+1]) begin
      hv = tag[CW] ? MINV : MAXV;
    end else if (hs > MAXV) begin
      hv = MAXV;
    end else if (hs < MINV) begin
      hv = MINV;
    end else begin
      hv    = hs;
      sat_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      h_o   <= hv[CW-1:0];
      sat_o <= sat_d;
    end
  end

endmodule

/* sv/plane_point_ray_test.sv */
// plane point classification, ray and segment intersection, top level
// throughput: one beat per cycle while the output is not stalled
// pipeline depth is set by the COORD_WIDTH+1 stage divider
// a stalled output holds the whole pipeline, nothing is dropped or repeated
// reset clears the plane registers and the valid line; payload is not reset
`timescale 1ns / 1ps
module plane_point_ray_test #(
  parameter int COORD_WIDTH = ppr_pkg::COORD_WIDTH,
  parameter int FRAC_BITS   = ppr_pkg::FRAC_BITS
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [1:0]                    command_i,
  input  logic signed [COORD_WIDTH-1:0] point_x_i,
  input  logic signed [COORD_WIDTH-1:0] point_y_i,
  input  logic signed [COORD_WIDTH-1:0] point_z_i,
  input  logic signed [COORD_WIDTH-1:0] vec_x_i,
  input  logic signed [COORD_WIDTH-1:0] vec_y_i,
  input  logic signed [COORD_WIDTH-1:0] vec_z_i,
  input  logic                          cfg_we_i,
  input  logic [1:0]                    cfg_index_i,
  input  logic [COORD_WIDTH-1:0]        cfg_data_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [1:0]                    side_o,
  output logic signed [COORD_WIDTH-1:0] signed_distance_o,
  output logic                          hit_o,
  output logic signed [COORD_WIDTH-1:0] hit_x_o,
  output logic signed [COORD_WIDTH-1:0] hit_y_o,
  output logic signed [COORD_WIDTH-1:0] hit_z_o,
  output logic                          saturated_o
);
  import ppr_pkg::*;

  localparam int CW  = COORD_WIDTH;
  localparam int FB  = FRAC_BITS;
  localparam int SW  = plane_width(CW, FB);
  localparam int LAT = CW + 8;
  localparam int SBD = CW + 5;

  // plane registers
  logic [CW-1:0] nx_q, ny_q, nz_q, off_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      nx_q  <= '0;
      ny_q  <= '0;
      nz_q  <= '0;
      off_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        REG_NORMAL_X:     nx_q  <= cfg_data_i;
        REG_NORMAL_Y:     ny_q  <= cfg_data_i;
        REG_NORMAL_Z:     nz_q  <= cfg_data_i;
        REG_PLANE_OFFSET: off_q <= cfg_data_i;
        default:          nx_q  <= nx_q;
      endcase
    end
  end

  logic en;
  assign in_stall_o = out_valid_o && out_stall_i;
  assign en         = !in_stall_o;

  logic [LAT-1:0] vld_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[LAT-2:0], in_valid_i};
    end
  end

  assign out_valid_o = vld_q[LAT-1];

  logic [2:0][CW-1:0] p_f;
  logic [2:0][CW:0]   m_mag_f;
  logic [2:0]         neg_f;
  logic [SW:0]        s_mag_f, den_mag_f;
  logic               s_neg_f, hit_f;
  logic [1:0]         side_f;

  ppr_front #(.CW(CW), .FB(FB), .SW(SW)) u_front (
    .clk_i     (clk_i),
    .en_i      (en),
    .cmd_i     (command_i),
    .nrm_i     ({nz_q, ny_q, nx_q}),
    .off_i     (off_q),
    .p_i       ({point_z_i, point_y_i, point_x_i}),
    .v_i       ({vec_z_i, vec_y_i, vec_x_i}),
    .p_o       (p_f),
    .m_mag_o   (m_mag_f),
    .neg_o     (neg_f),
    .s_mag_o   (s_mag_f),
    .s_neg_o   (s_neg_f),
    .den_mag_o (den_mag_f),
    .side_o    (side_f),
    .hit_o     (hit_f)
  );

  logic [2:0][CW-1:0] h_c;
  logic [2:0]         sat_c;

  for (genvar k = 0; k < 3; k++) begin : g_lane
    ppr_coord #(.CW(CW), .SW(SW)) u_coord (
      .clk_i     (clk_i),
      .en_i      (en),
      .p_i       (p_f[k]),
      .m_mag_i   (m_mag_f[k]),
      .neg_i     (neg_f[k]),
      .ns_mag_i  (s_mag_f),
      .den_mag_i (den_mag_f),
      .h_o       (h_c[k]),
      .sat_o     (sat_c[k])
    );
  end

  // distance: round the plane value by the fraction bits, then clip
  typedef struct packed {
    logic [1:0]    side;
    logic          hit;
    logic [CW-1:0] sdist;
    logic          dsat;
  } sband_t;

  localparam logic [SW+1:0] ONE     = (SW+2)'(1);
  localparam logic [SW+1:0] HALF    = (ONE << FB) >> 1;
  localparam logic [SW+1:0] POS_LIM = (SW+2)'({1'b0, {(CW-1){1'b1}}});
  localparam logic [SW+1:0] NEG_LIM = POS_LIM + ONE;

  logic [SW+1:0] rnd;
  sband_t        sb_d;
  sband_t        sb_q [SBD];

  always_comb begin
    rnd       = ((SW+2)'(s_mag_f) + HALF) >> FB;
    sb_d.side = side_f;
    sb_d.hit  = hit_f;
    sb_d.dsat = 1'b1;
    if (s_neg_f && rnd > NEG_LIM) begin
      sb_d.sdist = {1'b1, {(CW-1){1'b0}}};
    end else if (!s_neg_f && rnd > POS_LIM) begin
      sb_d.sdist = {1'b0, {(CW-1){1'b1}}};
    end else begin
      sb_d.sdist = s_neg_f ? -rnd[CW-1:0] : rnd[CW-1:0];
      sb_d.dsat  = 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      sb_q[0] <= sb_d;
      for (int i = 1; i < SBD; i++) begin
        sb_q[i] <= sb_q[i-1];
      end
    end
  end

  assign side_o            = sb_q[SBD-1].side;
  assign signed_distance_o = sb_q[SBD-1].sdist;
  assign hit_o             = sb_q[SBD-1].hit;
  assign hit_x_o           = sb_q[SBD-1].hit ? h_c[0] : '0;
  assign hit_y_o           = sb_q[SBD-1].hit ? h_c[1] : '0;
  assign hit_z_o           = sb_q[SBD-1].hit ? h_c[2] : '0;
  assign saturated_o       = sb_q[SBD-1].dsat || (sb_q[SBD-1].hit && (sat_c != '0));

  a_miss_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !hit_o) |-> (hit_x_o == '0 && hit_y_o == '0 && hit_z_o == '0))
    else $error("hit coordinates nonzero on a miss");

  a_on_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && side_o == SIDE_ON) |-> (signed_distance_o == '0))
    else $error("point on plane with nonzero distance");

  a_front_pos: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && side_o == SIDE_FRONT) |-> !signed_distance_o[CW-1])
    else $error("front side with negative distance");

endmodule
